### rtl/ct3_pkg.sv
package ct3_pkg;

    localparam int MAX_WIDTH_DEFAULT  = 1024;
    localparam int PIXEL_BITS_DEFAULT = 16;

    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 12;
    localparam int ROW_BITS        = 12;
    localparam int COL_OUT_BITS    = 10;
    localparam int CODE_BITS       = 8;
    localparam int CFG_INDEX_BITS  = 4;
    localparam int CFG_DATA_BITS   = 16;

    localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 12'd480;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 4'd1;

    localparam int BIT_UP_LEFT    = 7;
    localparam int BIT_UP         = 6;
    localparam int BIT_UP_RIGHT   = 5;
    localparam int BIT_LEFT       = 4;
    localparam int BIT_RIGHT      = 3;
    localparam int BIT_DOWN_LEFT  = 2;
    localparam int BIT_DOWN       = 1;
    localparam int BIT_DOWN_RIGHT = 0;

endpackage

### rtl/ct3_ram.sv
module ct3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/census_transform_3x3_unit.sv
// Channel  | Valid        | Stall        | Payload
// ---------+--------------+--------------+------------------------------------------
// in       | i_in_valid   | o_in_stall   | i_pixel, i_frame_start
// out      | o_out_valid  | i_out_stall  | o_code, o_center_row, o_center_col
// cfg      | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One pixel per cycle while o_in_stall is low; a result passes the window stage, then the output register.
// The line buffer read is registered, and each pixel waits in the window stage until the output register is free.
// After reset all MAX_WIDTH entries of both line buffers are cleared with the input stalled.
// The window stage and the output register let input continue while one result waits.
module census_transform_3x3_unit #(
    parameter int MAX_WIDTH  = ct3_pkg::MAX_WIDTH_DEFAULT,
    parameter int PIXEL_BITS = ct3_pkg::PIXEL_BITS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [PIXEL_BITS-1:0]               i_pixel,
    input  logic                                i_frame_start,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [ct3_pkg::CODE_BITS-1:0]       o_code,
    output logic [ct3_pkg::ROW_BITS-1:0]        o_center_row,
    output logic [ct3_pkg::COL_OUT_BITS-1:0]    o_center_col,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ct3_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [ct3_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RB = ct3_pkg::ROW_BITS;

    logic [ct3_pkg::WIDTH_REG_BITS-1:0]  r_width;
    logic [ct3_pkg::HEIGHT_REG_BITS-1:0] r_height;
    logic [RB-1:0]                       r_row;
    logic [CW-1:0]                       r_col;
    logic                                r_clr_busy;
    logic [CW-1:0]                       r_clr_addr;

    logic                  r_b_valid;
    logic [PIXEL_BITS-1:0] r_b_px;
    logic [RB-1:0]         r_b_row;
    logic [CW-1:0]         r_b_col;
    logic                  r_b_inside;
    logic                  r_b_res;
    logic                  r_fwd;
    logic [PIXEL_BITS-1:0] r_fwd_la;
    logic [PIXEL_BITS-1:0] r_fwd_lt;
    logic [PIXEL_BITS-1:0] r_win_a [3];
    logic [PIXEL_BITS-1:0] r_win_b [3];

    logic                          r_out_valid;
    logic [ct3_pkg::CODE_BITS-1:0] r_out_code;
    logic [RB-1:0]                 r_out_row;
    logic [CW-1:0]                 r_out_col;

    logic [12:0]           width_ext;
    logic [12:0]           w_eff_wide;
    logic [CW:0]           w_eff;
    logic [RB-1:0]         cur_row;
    logic [CW-1:0]         cur_col;
    logic                  in_take;
    logic                  active;
    logic                  load_b;
    logic                  b_advance;
    logic                  col_wrap;
    logic [RB-1:0]         n_row;
    logic [CW-1:0]         n_col;
    logic                  n_inside;
    logic                  n_res;
    logic [PIXEL_BITS-1:0] ram_la;
    logic [PIXEL_BITS-1:0] ram_lt;
    logic [PIXEL_BITS-1:0] b_la;
    logic [PIXEL_BITS-1:0] b_lt;
    logic [PIXEL_BITS-1:0] center;
    logic [ct3_pkg::CODE_BITS-1:0] n_code;
    logic                  wr_en;
    logic [CW-1:0]         wr_addr;
    logic [PIXEL_BITS-1:0] wr_la;
    logic [PIXEL_BITS-1:0] wr_lt;

    always_comb begin
        width_ext = {2'b00, r_width};
        if (width_ext == 13'd0) begin
            w_eff_wide = 13'd1;
        end else if (width_ext > 13'(MAX_WIDTH)) begin
            w_eff_wide = 13'(MAX_WIDTH);
        end else begin
            w_eff_wide = width_ext;
        end
        w_eff = (CW + 1)'(w_eff_wide);
    end

    assign cur_row   = i_frame_start ? '0 : r_row;
    assign cur_col   = i_frame_start ? '0 : r_col;
    assign b_advance = r_b_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_clr_busy || (r_b_valid && !b_advance);
    assign in_take   = i_in_valid && !o_in_stall;
    assign active    = cur_row < r_height;
    assign load_b    = in_take && active;

    always_comb begin
        col_wrap = ({1'b0, cur_col} + (CW + 1)'(1)) >= w_eff;
        if (col_wrap) begin
            n_col = '0;
            n_row = (cur_row == {RB{1'b1}}) ? cur_row : cur_row + RB'(1);
        end else begin
            n_col = cur_col + CW'(1);
            n_row = cur_row;
        end
        n_inside = (cur_row >= RB'(3))
                && (({1'b0, cur_row} + 13'd2) <= {1'b0, r_height})
                && (cur_col >= CW'(3))
                && (({2'b00, cur_col} + (CW + 2)'(2)) <= {1'b0, w_eff});
        n_res = (cur_row != '0) && (cur_col != '0);
    end

    assign b_la   = r_fwd ? r_fwd_la : ram_la;
    assign b_lt   = r_fwd ? r_fwd_lt : ram_lt;
    assign center = r_win_b[1];

    always_comb begin
        n_code = '0;
        if (r_b_inside) begin
            n_code[ct3_pkg::BIT_UP_LEFT]    = center <= r_win_a[0];
            n_code[ct3_pkg::BIT_UP]         = center <= r_win_b[0];
            n_code[ct3_pkg::BIT_UP_RIGHT]   = center <= b_lt;
            n_code[ct3_pkg::BIT_LEFT]       = center <= r_win_a[1];
            n_code[ct3_pkg::BIT_RIGHT]      = center <= b_la;
            n_code[ct3_pkg::BIT_DOWN_LEFT]  = center <= r_win_a[2];
            n_code[ct3_pkg::BIT_DOWN]       = center <= r_win_b[2];
            n_code[ct3_pkg::BIT_DOWN_RIGHT] = center <= r_b_px;
        end
    end

    assign wr_en   = r_clr_busy || b_advance;
    assign wr_addr = r_clr_busy ? r_clr_addr : r_b_col;
    assign wr_la   = r_clr_busy ? '0 : r_b_px;
    assign wr_lt   = r_clr_busy ? '0 : b_la;

    ct3_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_above (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_la),
        .i_rd_en   (load_b),
        .i_rd_addr (cur_col),
        .o_rd_data (ram_la)
    );

    ct3_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_two_above (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_lt),
        .i_rd_en   (load_b),
        .i_rd_addr (cur_col),
        .o_rd_data (ram_lt)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= ct3_pkg::WIDTH_RESET;
            r_height <= ct3_pkg::HEIGHT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ct3_pkg::CFG_IMAGE_WIDTH: begin
                    r_width <= i_cfg_data[ct3_pkg::WIDTH_REG_BITS-1:0];
                end
                ct3_pkg::CFG_IMAGE_HEIGHT: begin
                    r_height <= i_cfg_data[ct3_pkg::HEIGHT_REG_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == CW'(MAX_WIDTH - 1)) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (in_take) begin
            r_row <= active ? n_row : cur_row;
            r_col <= active ? n_col : cur_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_fwd     <= 1'b0;
        end else if (load_b) begin
            r_b_valid <= 1'b1;
            r_fwd     <= b_advance && (r_b_col == cur_col);
        end else if (b_advance) begin
            r_b_valid <= 1'b0;
            r_fwd     <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_b) begin
            r_b_px     <= i_pixel;
            r_b_row    <= cur_row;
            r_b_col    <= cur_col;
            r_b_inside <= n_inside;
            r_b_res    <= n_res;
            r_fwd_la   <= r_b_px;
            r_fwd_lt   <= b_la;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_advance) begin
            r_win_a[0] <= r_win_b[0];
            r_win_a[1] <= r_win_b[1];
            r_win_a[2] <= r_win_b[2];
            r_win_b[0] <= b_lt;
            r_win_b[1] <= b_la;
            r_win_b[2] <= r_b_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_advance) begin
            r_out_valid <= r_b_res;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_advance && r_b_res) begin
            r_out_code <= n_code;
            r_out_row  <= r_b_row - RB'(1);
            r_out_col  <= r_b_col - CW'(1);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_code       = r_out_code;
    assign o_center_row = r_out_row;
    assign o_center_col = ct3_pkg::COL_OUT_BITS'(r_out_col);

    a_clear_blocks_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> o_in_stall && !r_b_valid && !r_out_valid)
        else $error("request taken during line buffer clear");

    a_fwd_needs_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_b_valid)
        else $error("forwarded line data without an item in the window stage");

    a_code_interior : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_code != '0) |-> (r_out_row >= RB'(2) && r_out_col >= CW'(2)))
        else $error("nonzero code reported for a border center");

    a_stage_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !b_advance) |=> (r_b_valid && $stable(r_b_col) && $stable(r_b_px)))
        else $error("window stage item changed while blocked");

endmodule
